// File: rtl/motor_speed_pid_with_pwm_direction_core_assert.svh
// ----------------------------------------------------------------------------
// assertion macros for the motor speed pid core
// ----------------------------------------------------------------------------
`ifndef MOTOR_SPEED_PID_WITH_PWM_DIRECTION_CORE_ASSERT_SVH
`define MOTOR_SPEED_PID_WITH_PWM_DIRECTION_CORE_ASSERT_SVH

// same-cycle implication, checked out of reset
`define MSPID_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("mspid assertion failed");

// next-cycle implication, checked out of reset
`define MSPID_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("mspid assertion failed");

`endif

// File: rtl/mspid_pkg.sv
// ----------------------------------------------------------------------------
// mspid_pkg
// shared widths, constants and types of the motor speed pid core
// ----------------------------------------------------------------------------
package mspid_pkg;

  localparam int GAIN_FRAC_BITS = 8;
  localparam int SUM_WIDTH      = 32;

  localparam int ERR_W  = 16;
  localparam int GAIN_W = 16;
  localparam int DIFF_W = ERR_W + 1;
  localparam int SUM_W  = SUM_WIDTH;
  localparam int PP_W   = GAIN_W + ERR_W;
  localparam int PD_W   = GAIN_W + DIFF_W;
  localparam int PI_W   = GAIN_W + SUM_W;
  localparam int INC_W  = SUM_W + 18;
  localparam int LIM_W  = (INC_W > 42) ? INC_W : 42;
  localparam int Q_W    = LIM_W + 9;
  localparam int DUTY_W = 16;
  localparam int PCT_W  = 7;
  localparam int SHR    = (GAIN_FRAC_BITS - 8) & 7;
  localparam int SHL    = (8 - GAIN_FRAC_BITS) & 7;

  localparam logic signed [DUTY_W-1:0] DUTY_ONE = 16'sd256;
  localparam logic signed [DUTY_W-1:0] DUTY_MAX = 16'sd25600;
  localparam logic [PCT_W-1:0]         BRAKE_PCT = 7'd100;
  localparam logic signed [LIM_W-1:0]  INC_LIM  = {{(LIM_W-41){1'b0}}, 1'b1, 40'd0};

  typedef enum logic [1:0] {
    CFG_TARGET = 2'd0,
    CFG_GAIN_P = 2'd1,
    CFG_GAIN_I = 2'd2,
    CFG_GAIN_D = 2'd3
  } cfg_idx_e;

  typedef struct packed {
    logic signed [ERR_W-1:0]  target;
    logic signed [GAIN_W-1:0] gain_p;
    logic signed [GAIN_W-1:0] gain_i;
    logic signed [GAIN_W-1:0] gain_d;
  } cfg_t;

  typedef struct packed {
    logic signed [ERR_W-1:0]  err;
    logic signed [SUM_W-1:0]  sum;
    logic signed [DIFF_W-1:0] diff;
  } err_t;

  typedef struct packed {
    logic signed [ERR_W-1:0] err;
    logic signed [PP_W-1:0]  prod_p;
    logic signed [PD_W-1:0]  prod_d;
    logic signed [PI_W-1:0]  prod_i;
  } prod_t;

  typedef struct packed {
    logic [PCT_W-1:0]         duty_a;
    logic [PCT_W-1:0]         duty_b;
    logic signed [DUTY_W-1:0] duty_value;
    logic signed [ERR_W-1:0]  speed_error;
  } res_t;

endpackage

// File: rtl/mspid_if.sv
// ----------------------------------------------------------------------------
// mspid_in_if / mspid_out_if
// valid/ready channels for measured speed beats and duty result beats
// ----------------------------------------------------------------------------
interface mspid_in_if;
  logic              valid;
  logic              ready;
  logic signed [15:0] measured_rpm;

  modport source (output valid, output measured_rpm, input ready);
  modport sink   (input valid, input measured_rpm, output ready);
endinterface

interface mspid_out_if;
  logic              valid;
  logic              ready;
  logic [6:0]        duty_a;
  logic [6:0]        duty_b;
  logic signed [15:0] duty_value;
  logic signed [15:0] speed_error;

  modport source (output valid, output duty_a, output duty_b, output duty_value,
                  output speed_error, input ready);
  modport sink   (input valid, input duty_a, input duty_b, input duty_value,
                  input speed_error, output ready);
endinterface

// File: rtl/mspid_err_stage.sv
// ----------------------------------------------------------------------------
// mspid_err_stage
// saturated speed error, error sum and derivative term, with their state
// ----------------------------------------------------------------------------
module mspid_err_stage (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            load_i,
  input  logic signed [mspid_pkg::ERR_W-1:0] measured_i,
  input  mspid_pkg::cfg_t                 cfg_i,
  output mspid_pkg::err_t                 err_o
);

  localparam int EW = mspid_pkg::ERR_W;
  localparam int SW = mspid_pkg::SUM_W;

  logic signed [EW-1:0] last_q, last_d;
  logic signed [SW-1:0] sum_q, sum_d;
  mspid_pkg::err_t      err_q, err_d;

  logic signed [EW:0]   err_w;
  logic signed [EW-1:0] err_s;
  logic signed [SW:0]   sum_w;
  logic signed [SW-1:0] sum_s;

  always_comb begin
    err_w = $signed({cfg_i.target[EW-1], cfg_i.target}) - $signed({measured_i[EW-1], measured_i});
    case ({err_w[EW], err_w[EW-1]})
      2'b01:   err_s = {1'b0, {(EW-1){1'b1}}};
      2'b10:   err_s = {1'b1, {(EW-1){1'b0}}};
      default: err_s = err_w[EW-1:0];
    endcase

    sum_w = $signed({sum_q[SW-1], sum_q}) + (SW+1)'(err_s);
    case ({sum_w[SW], sum_w[SW-1]})
      2'b01:   sum_s = {1'b0, {(SW-1){1'b1}}};
      2'b10:   sum_s = {1'b1, {(SW-1){1'b0}}};
      default: sum_s = sum_w[SW-1:0];
    endcase

    err_d.err  = err_s;
    err_d.sum  = sum_s;
    err_d.diff = mspid_pkg::DIFF_W'(err_s) - mspid_pkg::DIFF_W'(last_q);

    last_d = last_q;
    sum_d  = sum_q;
    if (load_i) begin
      last_d = err_s;
      // sum restarts on an error sign change, after this beat used it
      sum_d  = (err_s[EW-1] ^ last_q[EW-1]) ? '0 : sum_s;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      last_q <= '0;
      sum_q  <= '0;
    end else begin
      last_q <= last_d;
      sum_q  <= sum_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      err_q <= err_d;
    end
  end

  assign err_o = err_q;

endmodule

// File: rtl/mspid_mul_stage.sv
// ----------------------------------------------------------------------------
// mspid_mul_stage
// proportional, derivative and integral gain products
// ----------------------------------------------------------------------------
module mspid_mul_stage (
  input  logic            clk_i,
  input  logic            load_i,
  input  mspid_pkg::cfg_t cfg_i,
  input  mspid_pkg::err_t err_i,
  output mspid_pkg::prod_t prod_o
);

  mspid_pkg::prod_t prod_q, prod_d;

  always_comb begin
    prod_d.err    = err_i.err;
    prod_d.prod_p = mspid_pkg::PP_W'(cfg_i.gain_p) * mspid_pkg::PP_W'(err_i.err);
    prod_d.prod_d = mspid_pkg::PD_W'(cfg_i.gain_d) * mspid_pkg::PD_W'(err_i.diff);
    prod_d.prod_i = mspid_pkg::PI_W'(cfg_i.gain_i) * mspid_pkg::PI_W'(err_i.sum);
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      prod_q <= prod_d;
    end
  end

  assign prod_o = prod_q;

endmodule

// File: rtl/mspid_duty_stage.sv
// ----------------------------------------------------------------------------
// mspid_duty_stage
// duty accumulator, direction floor, clamp and bridge split into the result
// ----------------------------------------------------------------------------
module mspid_duty_stage (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             load_i,
  input  mspid_pkg::cfg_t  cfg_i,
  input  mspid_pkg::prod_t prod_i,
  output mspid_pkg::res_t  res_o
);

  localparam int IW = mspid_pkg::INC_W;
  localparam int LW = mspid_pkg::LIM_W;
  localparam int QW = mspid_pkg::Q_W;
  localparam int DW = mspid_pkg::DUTY_W;

  logic signed [DW-1:0] acc_q, acc_d;
  mspid_pkg::res_t      res_q, res_d;

  logic signed [IW-1:0] inc;
  logic signed [LW-1:0] lim;
  logic signed [QW-1:0] q8;
  logic signed [QW-1:0] duty;
  logic signed [DW-1:0] duty_s;
  logic signed [DW-1:0] mag;

  always_comb begin
    inc = IW'(prod_i.prod_p) - IW'(prod_i.prod_d) + IW'(prod_i.prod_i);
    lim = LW'(inc);
    if (lim > mspid_pkg::INC_LIM) begin
      lim = mspid_pkg::INC_LIM;
    end else if (lim < -mspid_pkg::INC_LIM) begin
      lim = -mspid_pkg::INC_LIM;
    end

    if (mspid_pkg::GAIN_FRAC_BITS >= 8) begin
      q8 = QW'(lim >>> mspid_pkg::SHR);
    end else begin
      q8 = QW'(lim) <<< mspid_pkg::SHL;
    end

    duty = QW'(acc_q) + q8;
    if (cfg_i.target > 0 && duty < QW'(mspid_pkg::DUTY_ONE)) begin
      duty = QW'(mspid_pkg::DUTY_ONE);
    end else if (cfg_i.target < 0 && duty > -QW'(mspid_pkg::DUTY_ONE)) begin
      duty = -QW'(mspid_pkg::DUTY_ONE);
    end
    if (duty > QW'(mspid_pkg::DUTY_MAX)) begin
      duty = QW'(mspid_pkg::DUTY_MAX);
    end else if (duty < -QW'(mspid_pkg::DUTY_MAX)) begin
      duty = -QW'(mspid_pkg::DUTY_MAX);
    end
    duty_s = duty[DW-1:0];

    mag = duty_s[DW-1] ? -duty_s : duty_s;
    res_d.duty_value  = duty_s;
    res_d.speed_error = prod_i.err;
    if (duty_s > 0) begin
      res_d.duty_a = '0;
      res_d.duty_b = mag[14:8];
    end else if (duty_s < 0) begin
      res_d.duty_a = mag[14:8];
      res_d.duty_b = '0;
    end else begin
      res_d.duty_a = mspid_pkg::BRAKE_PCT;
      res_d.duty_b = mspid_pkg::BRAKE_PCT;
    end

    acc_d = load_i ? duty_s : acc_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_q <= '0;
    end else begin
      acc_q <= acc_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      res_q <= res_d;
    end
  end

  assign res_o = res_q;

endmodule

// File: rtl/motor_speed_pid_with_pwm_direction_core.sv
// ----------------------------------------------------------------------------
// motor_speed_pid_with_pwm_direction_core
// incremental pid speed controller with h-bridge duty outputs
// ----------------------------------------------------------------------------
// in_b carries one measured speed beat per control tick; out_b returns one
// beat per tick with the bridge duties, the clamped q7.8 duty and the
// saturated speed error. setpoint and gains are written through the cfg
// port (index 0 target, 1 kp, 2 ki, 3 kd) only while no beat is in flight;
// the user must keep to this; the block does not enforce it. three register
// stages: error/sum, gain products, duty accumulator with the result
// register. a result is valid once its beat has passed all three, and one
// beat per cycle is taken when out_b keeps up. the duty accumulator and the
// error sum advance as each beat passes through. reset clears the config
// registers, error state, duty accumulator and all valid bits. when out_b
// stalls, the result waits in its register and the two stages before it
// still fill, so up to three beats are held before in_b.ready drops.
// ----------------------------------------------------------------------------
`include "motor_speed_pid_with_pwm_direction_core_assert.svh"

module motor_speed_pid_with_pwm_direction_core (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_idx_i,
  input  logic [15:0] cfg_wdata_i,
  mspid_in_if.sink    in_b,
  mspid_out_if.source out_b
);

  mspid_pkg::cfg_t  cfg_q, cfg_d;
  mspid_pkg::err_t  err_s;
  mspid_pkg::prod_t prod_s;
  mspid_pkg::res_t  res_s;

  logic v1_q, v2_q, vo_q;
  logic adv_o, adv2, adv1;
  logic load1, load2, load_o;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      case (mspid_pkg::cfg_idx_e'(cfg_idx_i))
        mspid_pkg::CFG_TARGET: cfg_d.target = cfg_wdata_i;
        mspid_pkg::CFG_GAIN_P: cfg_d.gain_p = cfg_wdata_i;
        mspid_pkg::CFG_GAIN_I: cfg_d.gain_i = cfg_wdata_i;
        mspid_pkg::CFG_GAIN_D: cfg_d.gain_d = cfg_wdata_i;
        default:               cfg_d = cfg_q;
      endcase
    end
  end

  assign adv_o  = !vo_q || out_b.ready;
  assign load_o = v2_q && adv_o;
  assign adv2   = !v2_q || adv_o;
  assign load2  = v1_q && adv2;
  assign adv1   = !v1_q || adv2;
  assign load1  = in_b.valid && adv1;

  assign in_b.ready = adv1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '0;
      v1_q  <= 1'b0;
      v2_q  <= 1'b0;
      vo_q  <= 1'b0;
    end else begin
      cfg_q <= cfg_d;
      if (adv1) v1_q <= in_b.valid;
      if (adv2) v2_q <= v1_q;
      if (adv_o) vo_q <= v2_q;
    end
  end

  mspid_err_stage u_err (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .load_i     (load1),
    .measured_i (in_b.measured_rpm),
    .cfg_i      (cfg_q),
    .err_o      (err_s)
  );

  mspid_mul_stage u_mul (
    .clk_i  (clk_i),
    .load_i (load2),
    .cfg_i  (cfg_q),
    .err_i  (err_s),
    .prod_o (prod_s)
  );

  mspid_duty_stage u_duty (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .load_i (load_o),
    .cfg_i  (cfg_q),
    .prod_i (prod_s),
    .res_o  (res_s)
  );

  assign out_b.valid       = vo_q;
  assign out_b.duty_a      = res_s.duty_a;
  assign out_b.duty_b      = res_s.duty_b;
  assign out_b.duty_value  = res_s.duty_value;
  assign out_b.speed_error = res_s.speed_error;

  `MSPID_ASSERT_NOW(a_duty_range, vo_q,
    res_s.duty_value <= mspid_pkg::DUTY_MAX && res_s.duty_value >= -mspid_pkg::DUTY_MAX)
  `MSPID_ASSERT_NOW(a_brake, vo_q && res_s.duty_value == '0,
    res_s.duty_a == mspid_pkg::BRAKE_PCT && res_s.duty_b == mspid_pkg::BRAKE_PCT)
  `MSPID_ASSERT_NOW(a_one_side, vo_q && res_s.duty_value != '0,
    res_s.duty_a == '0 || res_s.duty_b == '0)
  `MSPID_ASSERT_NEXT(a_capture, in_b.valid && in_b.ready, v1_q)

endmodule
